FILE: rtl/nec_pkg.sv
// ----------------------------------------------------------------------------
// nec_pkg
// shared constants and types for the node-to-element cube average block
// ----------------------------------------------------------------------------
`default_nettype none

package nec_pkg;

    // default grid limits and value width
    localparam int DEF_MAX_X       = 256;
    localparam int DEF_MAX_Y       = 256;
    localparam int DEF_MAX_Z       = 1024;
    localparam int DEF_VALUE_WIDTH = 16;

    // configuration port
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 11;
    localparam int NXY_CFG_WIDTH   = 9;
    localparam int NZ_CFG_WIDTH    = 11;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_NODES_X = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_NODES_Y = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_NODES_Z = 2'd2;

    // entries in the queue between the front and the back
    localparam int QUEUE_DEPTH = 4;

    // per-transaction control that rides along with a quad sum
    typedef struct packed {
        logic emit;   // z index at least 1: an element comes out
        logic last;   // final element of the grid
    } nec_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/node_to_element_cube_average.sv
// ----------------------------------------------------------------------------
// node_to_element_cube_average
// streaming 2x2x2 box average from grid nodes to grid elements
// ----------------------------------------------------------------------------
// Node values enter in raster order (x fastest, then y, then z), one per
// cycle when element_stall stays low; each node whose x, y and z indices are
// all at least 1 closes a cube and yields one element, the floor of the
// eight-corner sum divided by eight, in element raster order, with
// last_element on the final element of the grid. The front walks the grid,
// adds each node to the previous one into an x-pair sum and keeps those in a
// row store of MAX_X entries; pairs from adjacent rows form quad sums that
// go through a four-entry queue to the back, which keeps quads in a plane
// store of MAX_X*MAX_Y entries and adds adjacent planes. Each store is read
// and rewritten at one address per transaction, so the sustained rate is one
// node per cycle; each node is registered in the front, the queue, stage 1
// and the output. The stores need no clearing: every entry is written
// before the walk reads it. Writing any of the three size registers
// restarts the walk at node (0,0,0); write them only while the block is
// idle. Sizes clamp to 2 up to the axis limit; x and y use cfg_data[8:0].
// ----------------------------------------------------------------------------
`default_nettype none

module node_to_element_cube_average #(
    parameter int MAX_X       = nec_pkg::DEF_MAX_X,
    parameter int MAX_Y       = nec_pkg::DEF_MAX_Y,
    parameter int MAX_Z       = nec_pkg::DEF_MAX_Z,
    parameter int VALUE_WIDTH = nec_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // configuration writes
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [nec_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [nec_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    // node stream
    input  wire logic                                 node_valid,
    output logic                                      node_stall,
    input  wire logic signed [VALUE_WIDTH-1:0]        node_value,
    // element stream
    output logic                                      element_valid,
    input  wire logic                                 element_stall,
    output logic signed [VALUE_WIDTH-1:0]             element_value,
    output logic                                      last_element
);
    import nec_pkg::*;

    localparam int PW = $clog2(MAX_X*MAX_Y);
    localparam int CW = $clog2(QUEUE_DEPTH+1);
    localparam int QW = $bits(nec_ctl_t) + PW + VALUE_WIDTH + 2;

    // front to queue
    logic                          push;
    logic signed [VALUE_WIDTH+1:0] push_quad;
    logic [PW-1:0]                 push_pidx;
    nec_ctl_t                      push_ctl;

    // queue to back
    logic                          pop;
    logic [QW-1:0]                 pop_data;
    logic                          queue_empty;
    logic [CW-1:0]                 queue_count;
    logic signed [VALUE_WIDTH+1:0] pop_quad;
    logic [PW-1:0]                 pop_pidx;
    nec_ctl_t                      pop_ctl;

    // size registers are plain flops, a write always lands at once
    assign cfg_ready = 1'b1;

    nec_front #(
        .MAX_X       (MAX_X),
        .MAX_Y       (MAX_Y),
        .MAX_Z       (MAX_Z),
        .VALUE_WIDTH (VALUE_WIDTH),
        .PW          (PW),
        .CW          (CW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .node_valid  (node_valid),
        .node_stall  (node_stall),
        .node_value  (node_value),
        .queue_count (queue_count),
        .push        (push),
        .push_quad   (push_quad),
        .push_pidx   (push_pidx),
        .push_ctl    (push_ctl)
    );

    // quad sum, plane address and control travel together
    nec_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_ctl, push_pidx, push_quad}),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty),
        .count     (queue_count)
    );

    assign {pop_ctl, pop_pidx, pop_quad} = pop_data;

    nec_back #(
        .MAX_X       (MAX_X),
        .MAX_Y       (MAX_Y),
        .VALUE_WIDTH (VALUE_WIDTH),
        .PW          (PW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .queue_empty   (queue_empty),
        .pop           (pop),
        .pop_quad      (pop_quad),
        .pop_pidx      (pop_pidx),
        .pop_ctl       (pop_ctl),
        .element_valid (element_valid),
        .element_stall (element_stall),
        .element_value (element_value),
        .last_element  (last_element)
    );

endmodule

`default_nettype wire

FILE: rtl/nec_queue.sv
// ----------------------------------------------------------------------------
// nec_queue
// small register fifo between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module nec_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [WIDTH-1:0]           push_data,
    input  wire logic                       pop,
    output logic      [WIDTH-1:0]           pop_data,
    output logic                            empty,
    output logic [$clog2(DEPTH+1)-1:0]      count
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = entry_reg[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign count    = count_reg;

endmodule

`default_nettype wire

FILE: rtl/nec_front.sv
// ----------------------------------------------------------------------------
// nec_front
// grid walk, configuration, previous node, row store of x-pair sums
// ----------------------------------------------------------------------------
`default_nettype none

module nec_front #(
    parameter int MAX_X       = nec_pkg::DEF_MAX_X,
    parameter int MAX_Y       = nec_pkg::DEF_MAX_Y,
    parameter int MAX_Z       = nec_pkg::DEF_MAX_Z,
    parameter int VALUE_WIDTH = nec_pkg::DEF_VALUE_WIDTH,
    parameter int PW          = $clog2(MAX_X*MAX_Y),
    parameter int CW          = $clog2(nec_pkg::QUEUE_DEPTH+1)
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    input  wire logic [nec_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [nec_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    input  wire logic                                 node_valid,
    output logic                                      node_stall,
    input  wire logic signed [VALUE_WIDTH-1:0]        node_value,
    input  wire logic [CW-1:0]                        queue_count,
    output logic                                      push,
    output logic signed [VALUE_WIDTH+1:0]             push_quad,
    output logic [PW-1:0]                             push_pidx,
    output nec_pkg::nec_ctl_t                         push_ctl
);
    import nec_pkg::*;

    localparam int XIW = $clog2(MAX_X);
    localparam int YIW = $clog2(MAX_Y);
    localparam int ZIW = $clog2(MAX_Z);
    localparam int XCW = $clog2(MAX_X+1);
    localparam int YCW = $clog2(MAX_Y+1);
    localparam int ZCW = $clog2(MAX_Z+1);
    localparam int VW  = VALUE_WIDTH;

    logic [XCW-1:0] nx_reg, nx_next;
    logic [YCW-1:0] ny_reg, ny_next;
    logic [ZCW-1:0] nz_reg, nz_next;
    logic [XIW-1:0] x_reg, x_next;
    logic [YIW-1:0] y_reg, y_next;
    logic [ZIW-1:0] z_reg, z_next;
    logic signed [VW-1:0] prev_reg;

    logic signed [VW:0] row_mem [MAX_X];
    logic signed [VW:0] row_rd_reg;

    logic                a_valid_reg, a_valid_next;
    logic signed [VW:0]  a_pair_reg;
    logic [PW-1:0]       a_pidx_reg;
    nec_ctl_t            a_ctl_reg, a_ctl_next;

    logic               accept;
    logic               restart;
    logic               x_end, y_end, z_end;
    logic signed [VW:0] pair;
    logic [NXY_CFG_WIDTH-1:0] cfg_xy;
    logic [NZ_CFG_WIDTH-1:0]  cfg_z;

    // credit check: room for the queued entries and the one in flight
    assign node_stall = (CW'(queue_count) + CW'(a_valid_reg)) >= CW'(QUEUE_DEPTH);
    assign accept     = node_valid && !node_stall;

    assign x_end = (XCW'(x_reg) == nx_reg - XCW'(1));
    assign y_end = (YCW'(y_reg) == ny_reg - YCW'(1));
    assign z_end = (ZCW'(z_reg) == nz_reg - ZCW'(1));
    assign pair  = (VW+1)'(prev_reg) + (VW+1)'(node_value);

    assign cfg_xy = cfg_data[NXY_CFG_WIDTH-1:0];
    assign cfg_z  = cfg_data[NZ_CFG_WIDTH-1:0];

    // register writes, out-of-range values clamp to the axis limits
    always_comb
    begin
        nx_next = nx_reg;
        ny_next = ny_reg;
        nz_next = nz_reg;
        restart = 1'b0;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_NODES_X:
                begin
                    restart = 1'b1;
                    if (cfg_xy < NXY_CFG_WIDTH'(2))
                        nx_next = XCW'(2);
                    else if (32'(cfg_xy) > MAX_X)
                        nx_next = XCW'(MAX_X);
                    else
                        nx_next = XCW'(cfg_xy);
                end
                REG_NODES_Y:
                begin
                    restart = 1'b1;
                    if (cfg_xy < NXY_CFG_WIDTH'(2))
                        ny_next = YCW'(2);
                    else if (32'(cfg_xy) > MAX_Y)
                        ny_next = YCW'(MAX_Y);
                    else
                        ny_next = YCW'(cfg_xy);
                end
                REG_NODES_Z:
                begin
                    restart = 1'b1;
                    if (cfg_z < NZ_CFG_WIDTH'(2))
                        nz_next = ZCW'(2);
                    else if (32'(cfg_z) > MAX_Z)
                        nz_next = ZCW'(MAX_Z);
                    else
                        nz_next = ZCW'(cfg_z);
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // raster walk
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (restart)
        begin
            x_next = '0;
            y_next = '0;
            z_next = '0;
        end
        else if (accept)
        begin
            if (!x_end)
            begin
                x_next = x_reg + XIW'(1);
            end
            else
            begin
                x_next = '0;
                if (!y_end)
                begin
                    y_next = y_reg + YIW'(1);
                end
                else
                begin
                    y_next = '0;
                    z_next = z_end ? '0 : z_reg + ZIW'(1);
                end
            end
        end
    end

    // classify: only nodes with x and y at least 1 go on to the back
    always_comb
    begin
        a_valid_next  = accept && (x_reg != '0) && (y_reg != '0);
        a_ctl_next.emit = (z_reg != '0);
        a_ctl_next.last = x_end && y_end && z_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg      <= XCW'(MAX_X);
            ny_reg      <= YCW'(MAX_Y);
            nz_reg      <= ZCW'(MAX_Z);
            x_reg       <= '0;
            y_reg       <= '0;
            z_reg       <= '0;
            prev_reg    <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            nx_reg      <= nx_next;
            ny_reg      <= ny_next;
            nz_reg      <= nz_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            z_reg       <= z_next;
            a_valid_reg <= a_valid_next;
            if (accept)
            begin
                prev_reg <= node_value;
            end
        end
    end

    // row store: read the pair from one row up, overwrite with this row's pair
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_rd_reg <= row_mem[x_reg];
            if (x_reg != '0)
            begin
                row_mem[x_reg] <= pair;
            end
            a_pair_reg <= pair;
            a_pidx_reg <= PW'(y_reg) * PW'(MAX_X) + PW'(x_reg);
            a_ctl_reg  <= a_ctl_next;
        end
    end

    assign push      = a_valid_reg;
    assign push_quad = (VW+2)'(row_rd_reg) + (VW+2)'(a_pair_reg);
    assign push_pidx = a_pidx_reg;
    assign push_ctl  = a_ctl_reg;

endmodule

`default_nettype wire

FILE: rtl/nec_back.sv
// ----------------------------------------------------------------------------
// nec_back
// plane store of quad sums, eight-corner mean and output register
// ----------------------------------------------------------------------------
`default_nettype none

module nec_back #(
    parameter int MAX_X       = nec_pkg::DEF_MAX_X,
    parameter int MAX_Y       = nec_pkg::DEF_MAX_Y,
    parameter int VALUE_WIDTH = nec_pkg::DEF_VALUE_WIDTH,
    parameter int PW          = $clog2(MAX_X*MAX_Y)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              queue_empty,
    output logic                                   pop,
    input  wire logic signed [VALUE_WIDTH+1:0]     pop_quad,
    input  wire logic [PW-1:0]                     pop_pidx,
    input  wire nec_pkg::nec_ctl_t                 pop_ctl,
    output logic                                   element_valid,
    input  wire logic                              element_stall,
    output logic signed [VALUE_WIDTH-1:0]          element_value,
    output logic                                   last_element
);
    import nec_pkg::*;

    localparam int VW    = VALUE_WIDTH;
    localparam int DEPTH = MAX_X * MAX_Y;

    logic signed [VW+1:0] plane_mem [DEPTH];
    logic signed [VW+1:0] plane_rd_reg;

    logic                 s1_valid_reg, s1_valid_next;
    logic signed [VW+1:0] s1_quad_reg;
    nec_ctl_t             s1_ctl_reg;

    logic                 out_valid_reg, out_valid_next;
    logic signed [VW-1:0] out_value_reg;
    logic                 out_last_reg;

    logic                 s1_go;
    logic                 s1_ready;
    logic                 load_out;
    logic signed [VW+2:0] sum;

    // stage 1 waits only when it carries an element and the output is held
    assign s1_go    = !(s1_ctl_reg.emit && out_valid_reg && element_stall);
    assign s1_ready = !s1_valid_reg || s1_go;
    assign pop      = !queue_empty && s1_ready;
    assign load_out = s1_valid_reg && s1_go && s1_ctl_reg.emit;
    assign sum      = (VW+3)'(s1_quad_reg) + (VW+3)'(plane_rd_reg);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_ready)
        begin
            s1_valid_next = pop;
        end
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!element_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // plane store: read the quad from one plane down, overwrite with this one
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            plane_rd_reg        <= plane_mem[pop_pidx];
            plane_mem[pop_pidx] <= pop_quad;
            s1_quad_reg         <= pop_quad;
            s1_ctl_reg          <= pop_ctl;
        end
    end

    // floor of the eight-corner sum divided by eight
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_value_reg <= sum[VW+2:3];
            out_last_reg  <= s1_ctl_reg.last;
        end
    end

    assign element_valid = out_valid_reg;
    assign element_value = out_value_reg;
    assign last_element  = out_last_reg;

endmodule

`default_nettype wire

FILE: rtl/nec_checker.sv
// ----------------------------------------------------------------------------
// nec_checker
// port-level checks for the node-to-element cube average block
// ----------------------------------------------------------------------------
`default_nettype none

module nec_checker #(
    parameter int VALUE_WIDTH = nec_pkg::DEF_VALUE_WIDTH
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          cfg_valid,
    input wire logic                          cfg_ready,
    input wire logic                          node_valid,
    input wire logic                          node_stall,
    input wire logic signed [VALUE_WIDTH-1:0] node_value,
    input wire logic                          element_valid,
    input wire logic                          element_stall,
    input wire logic signed [VALUE_WIDTH-1:0] element_value,
    input wire logic                          last_element
);

    // a held element transaction keeps its payload
    element_hold: assert property (@(posedge clk) disable iff (!rst_n)
        element_valid && element_stall |=>
            element_valid && $stable(element_value) && $stable(last_element))
        else $error("element transaction changed while stalled");

    // a held node transaction keeps its payload
    node_hold: assert property (@(posedge clk) disable iff (!rst_n)
        node_valid && node_stall |=> node_valid && $stable(node_value))
        else $error("node transaction changed while stalled");

    // reset leaves no element pending
    reset_empty: assert property (@(posedge clk)
        !rst_n |=> !element_valid)
        else $error("element valid during reset");

    // size writes never wait
    cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write held off");

    // when reset is released, no element is valid yet
    no_early_element: assert property (@(posedge clk)
        !rst_n ##1 rst_n |-> !element_valid)
        else $error("element without node transactions");

endmodule

bind node_to_element_cube_average nec_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_nec_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .node_valid    (node_valid),
    .node_stall    (node_stall),
    .node_value    (node_value),
    .element_valid (element_valid),
    .element_stall (element_stall),
    .element_value (element_value),
    .last_element  (last_element)
);

`default_nettype wire
